>>> sv/sba_pkg.sv
package sba_pkg;

    localparam int SLOTS      = 128;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int CHUNK_W    = 16;
    localparam int OFF_W      = $clog2(CHUNK_W);
    localparam int NUM_CHUNKS = (SLOTS + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_CW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 72;   // slot_index, new_value
    localparam int M_TDATA_W = 72;   // granted_index, read_value

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_GET   = 2'd2;
    localparam logic [OP_W-1:0] OP_SET   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BADIDX = 2'd2;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_ffs_res;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

>>> sv/sba_ram.sv
module sba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sba_ffs.sv
module sba_ffs (
    input  logic [sba_pkg::CHUNK_W-1:0] i_free,
    output sba_pkg::t_ffs_res           o_res
);
    import sba_pkg::*;

    // lowest set bit wins, so walk downwards
    always_comb begin
        o_res = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_res.found  = 1'b1;
                o_res.offset = OFF_W'(i);
            end
        end
    end

endmodule

>>> sv/slot_bitmap_allocator.sv
// First-free slot allocator over 128 slots, each holding a 64-bit value. One
// request beat in gives one response beat out. Allocate scans the allocation
// bitmap 16 slots a cycle through a shared first-free finder until a free
// slot is found or the last chunk is searched; a refused allocate on a full
// table goes straight to the done state, as do free and set, while a valid get
// passes through a read state for the value memory's registered read. A new
// request is taken once the previous result has moved into the output register,
// which may still be waiting on tready. The bitmap, count and per-slot written
// marks clear in the reset cycle; a slot never written since reset reads as zero.
module slot_bitmap_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sba_pkg::S_TDATA_W-1:0]   i_s_tdata,   // slot_index, new_value
    input  logic [sba_pkg::OP_W-1:0]        i_s_tuser,   // op
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sba_pkg::M_TDATA_W-1:0]   o_m_tdata,   // granted_index, read_value
    output logic [sba_pkg::STATUS_W-1:0]    o_m_tuser    // status
);
    import sba_pkg::*;

    t_state r_state, n_state;
    logic [SLOTS-1:0]    r_map, n_map;
    logic [SLOTS-1:0]    r_written, n_written;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CHUNK_CW-1:0] r_chunk, n_chunk;
    logic                r_rd_written, n_rd_written;

    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_grant, n_res_grant;
    logic [VAL_W-1:0]    r_res_rdata, n_res_rdata;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_grant, n_out_grant;
    logic [VAL_W-1:0]    r_out_rdata, n_out_rdata;

    logic [OP_W-1:0]   in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [VAL_W-1:0]  in_val;
    logic [SLOT_W-1:0] in_slot;
    logic              accept;
    logic              idx_ok;
    logic              ram_we;
    logic [VAL_W-1:0]  ram_rdata;
    logic [PAD_W-1:0]  map_pad;
    logic [SLOT_W-1:0] scan_slot;
    logic              out_free;
    t_ffs_res          ffs;

    assign in_op   = i_s_tuser;
    assign in_idx  = i_s_tdata[IDX_W-1:0];
    assign in_val  = i_s_tdata[IDX_W +: VAL_W];
    assign in_slot = in_idx[SLOT_W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign idx_ok     = (in_idx < IDX_W'(SLOTS)) && r_map[in_slot];
    assign ram_we     = accept && (in_op == OP_SET) && idx_ok;
    assign out_free   = !r_out_valid || i_m_tready;

    // slots past the end read as taken
    always_comb begin
        map_pad = '1;
        map_pad[SLOTS-1:0] = r_map;
    end

    sba_ffs u_ffs (
        .i_free (~map_pad[r_chunk*CHUNK_W +: CHUNK_W]),
        .o_res  (ffs)
    );

    assign scan_slot = SLOT_W'({r_chunk, ffs.offset});

    sba_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot),
        .i_wdata (in_val),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_map        = r_map;
        n_written    = r_written;
        n_count      = r_count;
        n_chunk      = r_chunk;
        n_rd_written = r_rd_written;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_res_rdata  = r_res_rdata;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        n_out_rdata  = r_out_rdata;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = STS_OK;
                    n_res_grant  = '0;
                    n_res_rdata  = '0;
                    n_state      = S_DONE;
                    if (in_op == OP_ALLOC) begin
                        if (r_count >= CNT_W'(SLOTS)) begin
                            n_res_status = STS_FULL;
                        end else begin
                            n_chunk = '0;
                            n_state = S_SCAN;
                        end
                    end else if (!idx_ok) begin
                        n_res_status = STS_BADIDX;
                    end else if (in_op == OP_FREE) begin
                        n_map[in_slot] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end else if (in_op == OP_GET) begin
                        n_rd_written = r_written[in_slot];
                        n_state      = S_READ;
                    end else begin
                        n_written[in_slot] = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (ffs.found) begin
                    n_map[scan_slot] = 1'b1;
                    n_count          = r_count + 1'b1;
                    n_res_grant      = IDX_W'(scan_slot);
                    n_state          = S_DONE;
                end else if (r_chunk == CHUNK_CW'(NUM_CHUNKS - 1)) begin
                    n_res_status = STS_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_READ: begin
                n_res_rdata = r_rd_written ? ram_rdata : '0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_grant  = r_res_grant;
                    n_out_rdata  = r_res_rdata;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map       <= '0;
            r_written   <= '0;
            r_count     <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_written   <= n_written;
            r_count     <= n_count;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_written <= n_rd_written;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_res_rdata  <= n_res_rdata;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
        r_out_rdata  <= n_out_rdata;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {r_out_rdata, r_out_grant};

endmodule
